// File: rtl/core/tts_pkg.sv
// Shared types and constants for the textured triangle pixel shader core.
// No dependencies; the core takes everything by scoped name.
package tts_pkg;

  // Fixed-point formats
  localparam int CoordFrac = 4;                   // fraction bits of vertex x,y
  localparam int UvFrac    = 14;                  // fraction bits of u,v
  localparam int CoordW    = 13 + CoordFrac;      // doubled coordinate width
  localparam int DiffW     = CoordW + 1;          // coordinate difference width
  localparam int ProdW     = 2 * DiffW;           // edge product width
  localparam int EdgeW     = ProdW + 1;           // edge function width
  localparam int DenW      = ProdW;               // normalized weight width
  localparam int NumW      = DenW + 16;           // weighted u or v sum width
  localparam int ScaledW   = NumW + 9;            // sum times texture size
  localparam int RemW      = ScaledW - UvFrac;    // dividend width
  localparam int DivBits   = 11;                  // quotient bits (texel index)
  localparam int PipeLat   = 18;                  // pipeline depth, request to result

  // Texture memory
  localparam int TexAw    = 16;
  localparam int TexDepth = 1 << TexAw;

  // Request commands
  typedef enum logic {
    CmdWrite = 1'b0,
    CmdShade = 1'b1
  } cmd_e;

  // Register indexes
  typedef enum logic [3:0] {
    RegVertexA     = 4'd0,
    RegVertexB     = 4'd1,
    RegVertexC     = 4'd2,
    RegTexWidth    = 4'd3,
    RegTexHeight   = 4'd4,
    RegBorderColor = 4'd5,
    RegScreenW     = 4'd6,
    RegScreenH     = 4'd7
  } reg_idx_e;

  // Per-request sideband that travels down the pipeline
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] idx;
    logic [23:0] wcol;
    logic [10:0] px;
    logic [10:0] py;
    logic        ok;     // on screen (early) / inside triangle (later)
  } side_t;

endpackage

// File: rtl/core/textured_triangle_pixel_shader_core.sv
// Textured triangle pixel shader core: barycentric nearest-texel mapping.
// Depends on tts_pkg for formats, command codes, register indexes and sideband type.

// The core takes one request per clock and never stalls (busy_o stays low).
// A shade request gives its result on done_o; a texel write takes a slot in
// the same pipeline, reaches the texture memory port at the same stage as
// shade reads, and gives no result. The pipeline holds the edge and weight
// multiplies (5 stages), an 11-stage restoring divider per texture axis, the
// address stage and the texture memory read. Results appear for one cycle
// only and must be taken. Registers may be written only while no request is
// in flight.
module textured_triangle_pixel_shader_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cmd_i,
  input  logic [15:0] texel_index_i,
  input  logic [23:0] texel_color_i,
  input  logic [10:0] pixel_x_i,
  input  logic [10:0] pixel_y_i,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output logic        done_o,
  output logic        draw_o,
  output logic [10:0] out_x_o,
  output logic [10:0] out_y_o,
  output logic [23:0] color_o
);

  localparam int CW = tts_pkg::CoordW;
  localparam int DW = tts_pkg::DiffW;
  localparam int PW = tts_pkg::ProdW;
  localparam int EW = tts_pkg::EdgeW;
  localparam int NW = tts_pkg::DenW;
  localparam int SW = tts_pkg::NumW;
  localparam int RW = tts_pkg::RemW;
  localparam int QB = tts_pkg::DivBits;
  localparam int TexAwL = tts_pkg::TexAw;

  // ---------------------------------------------------------------- config
  logic [63:0] vtx_q [3];
  logic [8:0]  tw_q, th_q;
  logic [23:0] border_q;
  logic [11:0] sw_q, sh_q;

  // Write registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_q[0] <= '0;
      vtx_q[1] <= '0;
      vtx_q[2] <= '0;
      tw_q     <= 9'd256;
      th_q     <= 9'd256;
      border_q <= '0;
      sw_q     <= 12'd640;
      sh_q     <= 12'd480;
    end else if (cfg_we_i) begin
      case (tts_pkg::reg_idx_e'(cfg_idx_i))
        tts_pkg::RegVertexA:     vtx_q[0] <= cfg_data_i;
        tts_pkg::RegVertexB:     vtx_q[1] <= cfg_data_i;
        tts_pkg::RegVertexC:     vtx_q[2] <= cfg_data_i;
        tts_pkg::RegTexWidth:    tw_q     <= cfg_data_i[8:0];
        tts_pkg::RegTexHeight:   th_q     <= cfg_data_i[8:0];
        tts_pkg::RegBorderColor: border_q <= cfg_data_i[23:0];
        tts_pkg::RegScreenW:     sw_q     <= cfg_data_i[11:0];
        tts_pkg::RegScreenH:     sh_q     <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // ------------------------------------------------------- pipeline regs
  logic                p1_v_q, p2_v_q, p3_v_q, p4_v_q, pm_v_q, pr_v_q;
  tts_pkg::side_t      p1_s_q, p2_s_q, p3_s_q, p4_s_q, p5_s_d, pm_s_q, pr_s_q;
  logic signed [EW-1:0] p2_n1_q, p2_n2_q, p2_d_q;
  logic [NW-1:0]       p3_n_q [3];
  logic [NW-1:0]       p3_d_q, p4_d_q;
  logic [SW-1:0]       p4_pu_q [3];
  logic [SW-1:0]       p4_pv_q [3];
  logic [TexAwL-1:0]   pm_addr_q;
  logic                pm_inr_q, pr_inr_q;
  logic [23:0]         rd_q;

  // divider stages
  logic                dv_v_q   [QB+1];
  tts_pkg::side_t      dv_s_q   [QB+1];
  logic [NW-1:0]       dv_d_q   [QB+1];
  logic [RW-1:0]       dv_ru_q  [QB+1];
  logic [RW-1:0]       dv_rv_q  [QB+1];
  logic [QB-1:0]       dv_qu_q  [QB+1];
  logic [QB-1:0]       dv_qv_q  [QB+1];
  logic [RW-1:0]       dv_ru_d  [QB+1];
  logic [RW-1:0]       dv_rv_d  [QB+1];
  logic [QB-1:0]       dv_qu_d  [QB+1];
  logic [QB-1:0]       dv_qv_d  [QB+1];

  // ------------------------------------------------ stage 1: edge functions
  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vy [3];
  logic signed [CW-1:0] cx, cy;
  logic signed [DW-1:0] dy12, dx21, dy20, dx02, ex, ey, ax, ay;
  logic signed [PW-1:0] m_d0, m_d1, m_a0, m_a1, m_b0, m_b1;
  logic                 onscreen;
  tts_pkg::side_t       p1_s_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx[i] = CW'($signed(vtx_q[i][63:48])) <<< 1;
      vy[i] = CW'($signed(vtx_q[i][47:32])) <<< 1;
    end
    cx   = CW'($signed({1'b0, p1_s_q.px, 1'b1})) <<< tts_pkg::CoordFrac;
    cy   = CW'($signed({1'b0, p1_s_q.py, 1'b1})) <<< tts_pkg::CoordFrac;
    dy12 = DW'(vy[1]) - DW'(vy[2]);
    dx21 = DW'(vx[2]) - DW'(vx[1]);
    dy20 = DW'(vy[2]) - DW'(vy[0]);
    dx02 = DW'(vx[0]) - DW'(vx[2]);
    ax   = DW'(vx[0]) - DW'(vx[2]);
    ay   = DW'(vy[0]) - DW'(vy[2]);
    ex   = DW'(cx) - DW'(vx[2]);
    ey   = DW'(cy) - DW'(vy[2]);
    m_d0 = dy12 * ax;
    m_d1 = dx21 * ay;
    m_a0 = dy12 * ex;
    m_a1 = dx21 * ey;
    m_b0 = dy20 * ex;
    m_b1 = dx02 * ey;
    onscreen = ({1'b0, p1_s_q.px} < sw_q) && ({1'b0, p1_s_q.py} < sh_q);
    p1_s_d    = p1_s_q;
    p1_s_d.ok = onscreen;
  end

  // --------------------------------------------- stage 2: normalize signs
  logic                 neg;
  logic signed [EW-1:0] dn, n1n, n2n;
  logic signed [EW:0]   n3n;
  tts_pkg::side_t       p2_s_d;

  always_comb begin
    neg = p2_d_q[EW-1];
    dn  = neg ? -p2_d_q  : p2_d_q;
    n1n = neg ? -p2_n1_q : p2_n1_q;
    n2n = neg ? -p2_n2_q : p2_n2_q;
    n3n = (EW+1)'(dn) - (EW+1)'(n1n) - (EW+1)'(n2n);
    p2_s_d    = p2_s_q;
    p2_s_d.ok = p2_s_q.ok && (dn != '0) && !n1n[EW-1] && !n2n[EW-1] && !n3n[EW];
  end

  // ------------------------------------ stage 5: scale by texture size
  logic [SW-1:0]             sum_u, sum_v;
  logic [tts_pkg::ScaledW-1:0] sc_u, sc_v;

  always_comb begin
    sum_u = p4_pu_q[0] + p4_pu_q[1] + p4_pu_q[2];
    sum_v = p4_pv_q[0] + p4_pv_q[1] + p4_pv_q[2];
    sc_u  = tts_pkg::ScaledW'(sum_u) * tts_pkg::ScaledW'(tw_q);
    sc_v  = tts_pkg::ScaledW'(sum_v) * tts_pkg::ScaledW'(th_q);
    p5_s_d = p4_s_q;
  end

  // ------------------------------------- divider: one quotient bit a stage
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      logic [RW:0] ds;
      ds = (RW+1)'(dv_d_q[k]) << (QB - 1 - k);
      dv_ru_d[k+1] = dv_ru_q[k];
      dv_rv_d[k+1] = dv_rv_q[k];
      dv_qu_d[k+1] = dv_qu_q[k];
      dv_qv_d[k+1] = dv_qv_q[k];
      if ({1'b0, dv_ru_q[k]} >= ds) begin
        dv_ru_d[k+1] = RW'({1'b0, dv_ru_q[k]} - ds);
        dv_qu_d[k+1][QB-1-k] = 1'b1;
      end
      if ({1'b0, dv_rv_q[k]} >= ds) begin
        dv_rv_d[k+1] = RW'({1'b0, dv_rv_q[k]} - ds);
        dv_qv_d[k+1][QB-1-k] = 1'b1;
      end
    end
    dv_ru_d[0] = RW'(sc_u >> tts_pkg::UvFrac);
    dv_rv_d[0] = RW'(sc_v >> tts_pkg::UvFrac);
    dv_qu_d[0] = '0;
    dv_qv_d[0] = '0;
  end

  // ------------------------------------------- address stage
  logic [QB-1:0]  tx, ty;
  logic [20:0]    lin;
  logic           inr;
  logic [TexAwL-1:0] addr_d;

  always_comb begin
    tx  = dv_qu_q[QB];
    ty  = dv_qv_q[QB];
    inr = ({1'b0, tx} < 12'(tw_q)) && ({1'b0, ty} < 12'(th_q));
    lin = 21'(ty) * 21'(tw_q) + 21'(tx);
    if (dv_s_q[QB].cmd == tts_pkg::CmdWrite) begin
      addr_d = TexAwL'(dv_s_q[QB].idx);
    end else begin
      addr_d = lin[TexAwL-1:0];
    end
  end

  // ---------------------------------------------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      pm_v_q <= 1'b0;
      pr_v_q <= 1'b0;
      for (int k = 0; k <= QB; k++) dv_v_q[k] <= 1'b0;
    end else begin
      p1_v_q    <= start_i && !busy_o;
      p2_v_q    <= p1_v_q;
      p3_v_q    <= p2_v_q;
      p4_v_q    <= p3_v_q;
      dv_v_q[0] <= p4_v_q;
      for (int k = 0; k < QB; k++) dv_v_q[k+1] <= dv_v_q[k];
      pm_v_q    <= dv_v_q[QB];
      pr_v_q    <= pm_v_q;
    end
  end

  // ---------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    // take the request
    p1_s_q.cmd  <= tts_pkg::cmd_e'(cmd_i);
    p1_s_q.idx  <= texel_index_i;
    p1_s_q.wcol <= texel_color_i;
    p1_s_q.px   <= pixel_x_i;
    p1_s_q.py   <= pixel_y_i;
    p1_s_q.ok   <= 1'b0;
    // edge functions
    p2_s_q  <= p1_s_d;
    p2_d_q  <= EW'(m_d0) + EW'(m_d1);
    p2_n1_q <= EW'(m_a0) + EW'(m_a1);
    p2_n2_q <= EW'(m_b0) + EW'(m_b1);
    // normalized weights
    p3_s_q    <= p2_s_d;
    p3_d_q    <= NW'(dn);
    p3_n_q[0] <= NW'(n1n);
    p3_n_q[1] <= NW'(n2n);
    p3_n_q[2] <= NW'(n3n);
    // weight times u and v
    p4_s_q <= p3_s_q;
    p4_d_q <= p3_d_q;
    for (int i = 0; i < 3; i++) begin
      p4_pu_q[i] <= SW'(p3_n_q[i]) * SW'(vtx_q[i][31:16]);
      p4_pv_q[i] <= SW'(p3_n_q[i]) * SW'(vtx_q[i][15:0]);
    end
    // divider
    dv_s_q[0]  <= p5_s_d;
    dv_d_q[0]  <= p4_d_q;
    dv_ru_q[0] <= dv_ru_d[0];
    dv_rv_q[0] <= dv_rv_d[0];
    dv_qu_q[0] <= dv_qu_d[0];
    dv_qv_q[0] <= dv_qv_d[0];
    for (int k = 0; k < QB; k++) begin
      dv_s_q[k+1]  <= dv_s_q[k];
      dv_d_q[k+1]  <= dv_d_q[k];
      dv_ru_q[k+1] <= dv_ru_d[k+1];
      dv_rv_q[k+1] <= dv_rv_d[k+1];
      dv_qu_q[k+1] <= dv_qu_d[k+1];
      dv_qv_q[k+1] <= dv_qv_d[k+1];
    end
    // memory stage
    pm_s_q    <= dv_s_q[QB];
    pm_addr_q <= addr_d;
    pm_inr_q  <= inr;
    // result stage
    pr_s_q    <= pm_s_q;
    pr_inr_q  <= pm_inr_q;
  end

  // ---------------------------------------------------- texture memory
  logic [23:0] tex_mem [tts_pkg::TexDepth];

  // Write or read at one stage so requests see memory in order
  always_ff @(posedge clk_i) begin
    if (pm_v_q && pm_s_q.cmd == tts_pkg::CmdWrite) begin
      tex_mem[pm_addr_q] <= pm_s_q.wcol;
    end else begin
      rd_q <= tex_mem[pm_addr_q];
    end
  end

  // ---------------------------------------------------- result
  assign done_o  = pr_v_q && (pr_s_q.cmd == tts_pkg::CmdShade);
  assign draw_o  = pr_s_q.ok;
  assign out_x_o = pr_s_q.px;
  assign out_y_o = pr_s_q.py;
  assign color_o = !pr_s_q.ok ? 24'd0 : (pr_inr_q ? rd_q : border_q);

  // ---------------------------------------------------- assertions
  a_no_color_undrawn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !draw_o) |-> (color_o == 24'd0))
    else $error("undrawn pixel carries a color");

  a_draw_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && draw_o) |-> (({1'b0, out_x_o} < sw_q) && ({1'b0, out_y_o} < sh_q)))
    else $error("drawn pixel lies off screen");

  a_no_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pm_v_q && pm_s_q.cmd == tts_pkg::CmdWrite) |=> !done_o)
    else $error("texel write produced a result");

endmodule
